>>> rtl/core/id3v2_tag_frame_parser_core_defines.svh
// Assertion macros for the tag parser core
`ifndef ID3V2_TAG_FRAME_PARSER_CORE_DEFINES_SVH
`define ID3V2_TAG_FRAME_PARSER_CORE_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define ID3P_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);
`define ID3P_ASSERT_NORST(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);
`else
`define ID3P_ASSERT(lbl, prop, msg)
`define ID3P_ASSERT_NORST(lbl, prop, msg)
`endif
`endif

>>> rtl/core/id3p_pkg.sv
package id3p_pkg;
    typedef enum logic [2:0] {
        EV_ACCEPT = 3'd0,
        EV_ENC    = 3'd1,
        EV_TEXT   = 3'd2,
        EV_DONE   = 3'd3,
        EV_BAD    = 3'd4
    } t_event;

    typedef struct packed {
        logic [2:0] event_res;
        logic [1:0] field_kind;
        logic [7:0] value;
        logic       last;
    } t_res;

    typedef struct packed {
        logic [1:0] n;
        t_res       r0;
        t_res       r1;
    } t_push;

    localparam logic [28:0] CONSUMED_MAX = 29'h1FFF_FFFF;
    localparam logic [31:0] SKIP_MAX     = 32'h0FFF_FFFF;

    localparam logic [31:0] ID_TPE1 = 32'h5450_4531;
    localparam logic [31:0] ID_TALB = 32'h5441_4C42;
    localparam logic [31:0] ID_TIT2 = 32'h5449_5432;
    localparam logic [31:0] ID_TRCK = 32'h5452_434B;
    localparam logic [31:0] ID_TP1  = 32'h0054_5031;
    localparam logic [31:0] ID_TAL  = 32'h0054_414C;
    localparam logic [31:0] ID_TT2  = 32'h0054_5432;
    localparam logic [31:0] ID_TRK  = 32'h0054_524B;
endpackage

>>> rtl/core/id3p_front.sv
module id3p_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  logic [7:0]     i_stream_byte,
    input  logic           i_file_start,
    input  logic           i_space,
    output id3p_pkg::t_push o_push
);
    import id3p_pkg::*;

    typedef enum logic [3:0] {
        PH_IDLE, PH_HDR, PH_EXT_SIZE, PH_EXT_SKIP, PH_FRAME,
        PH_FIELD_ENC, PH_FIELD_TEXT, PH_SKIP, PH_DONE
    } t_phase;

    t_phase      r_phase, n_phase, e_phase;
    logic [3:0]  r_pos, n_pos, e_pos;
    logic [2:0]  r_ver, n_ver, e_ver;
    logic [7:0]  r_flags, n_flags, e_flags;
    logic [27:0] r_tlen, n_tlen, e_tlen;
    logic [28:0] r_cons, n_cons, e_cons;
    logic [31:0] r_fid, n_fid, e_fid;
    logic [31:0] r_pl, n_pl, e_pl;
    logic [1:0]  r_cf, n_cf, e_cf;
    logic [27:0] r_skip, n_skip, e_skip;

    logic        acc;
    logic        do_bnd;
    logic        bnd_ok;
    logic        bad;
    logic        v2;
    logic [3:0]  idlen;
    logic [3:0]  hlen;
    logic [31:0] skv;
    logic [2:0]  kind;
    t_push       push;
    t_res        res;

    assign o_ready = i_space;
    assign acc     = i_valid && i_space;

    always_comb begin
        if (i_file_start) begin
            e_phase = PH_HDR;  e_pos = '0; e_ver = '0; e_flags = '0; e_tlen = '0;
            e_cons = '0; e_fid = '0; e_pl = '0; e_cf = '0; e_skip = '0;
        end else begin
            e_phase = r_phase; e_pos = r_pos; e_ver = r_ver; e_flags = r_flags;
            e_tlen = r_tlen; e_cons = r_cons; e_fid = r_fid; e_pl = r_pl;
            e_cf = r_cf; e_skip = r_skip;
        end
    end

    always_comb begin
        n_phase = e_phase; n_pos = e_pos; n_ver = e_ver; n_flags = e_flags;
        n_tlen = e_tlen; n_cons = e_cons; n_fid = e_fid; n_pl = e_pl;
        n_cf = e_cf; n_skip = e_skip;
        push   = '0;
        res    = '0;
        do_bnd = 1'b0;
        bad    = 1'b0;
        skv    = '0;
        kind   = 3'd4;
        v2     = (e_ver == 3'd2);
        idlen  = v2 ? 4'd3 : 4'd4;
        hlen   = v2 ? 4'd6 : 4'd10;
        bnd_ok = 1'b0;

        if (e_phase != PH_IDLE && e_phase != PH_HDR && e_phase != PH_DONE
                && r_cons != CONSUMED_MAX) begin
            if (e_cons != CONSUMED_MAX) n_cons = e_cons + 29'd1;
        end

        unique case (e_phase)
            PH_HDR: begin
                bad = (e_cf != 2'd0);
                if ((e_pos == 4'd0 && i_stream_byte != 8'h49)
                        || (e_pos == 4'd1 && i_stream_byte != 8'h44)
                        || (e_pos == 4'd2 && i_stream_byte != 8'h33)) bad = 1'b1;
                if (e_pos == 4'd3) begin
                    if (i_stream_byte < 8'd2 || i_stream_byte > 8'd4) bad = 1'b1;
                    else n_ver = i_stream_byte[2:0];
                end
                if (e_pos == 4'd4 && i_stream_byte == 8'hFF) bad = 1'b1;
                if (e_pos == 4'd5) begin
                    if (i_stream_byte[3:0] != 4'd0) bad = 1'b1;
                    n_flags = i_stream_byte;
                end
                if (e_pos >= 4'd6) begin
                    if (i_stream_byte[7]) bad = 1'b1;
                    n_tlen = {e_tlen[20:0], i_stream_byte[6:0]};
                end
                n_cf  = bad ? 2'd1 : e_cf;
                n_pos = e_pos + 4'd1;
                if (e_pos == 4'd9) begin
                    if (bad) begin
                        res.event_res = EV_BAD;
                        push.r0 = res;
                        push.n  = 2'd1;
                        n_phase = PH_DONE;
                    end else begin
                        n_cf = 2'd0;
                        res.event_res = EV_ACCEPT;
                        res.value     = {5'd0, n_ver};
                        push.r0 = res;
                        push.n  = 2'd1;
                        if (n_ver >= 3'd3 && n_flags[6]) begin
                            n_phase = PH_EXT_SIZE;
                            n_pos   = '0;
                            n_pl    = '0;
                        end else begin
                            do_bnd = 1'b1;
                        end
                    end
                end
            end
            PH_EXT_SIZE: begin
                if (e_ver == 3'd4) n_pl = {e_pl[24:0], i_stream_byte[6:0]};
                else n_pl = {e_pl[23:0], i_stream_byte};
                n_pos = e_pos + 4'd1;
                if (n_pos >= 4'd4) begin
                    if (e_ver == 3'd4) skv = (n_pl >= 32'd4) ? n_pl - 32'd4 : 32'd0;
                    else skv = (n_pl > SKIP_MAX) ? SKIP_MAX : n_pl;
                    n_skip = skv[27:0];
                    n_pl   = '0;
                    if (skv == 32'd0) do_bnd = 1'b1;
                    else n_phase = PH_EXT_SKIP;
                end
            end
            PH_EXT_SKIP: begin
                if (e_skip != 28'd0) n_skip = e_skip - 28'd1;
                if (n_skip == 28'd0) do_bnd = 1'b1;
            end
            PH_FRAME: begin
                if (e_pos < idlen) begin
                    n_fid = {e_fid[23:0], i_stream_byte};
                end else if (e_pos < (idlen + idlen)) begin
                    if (e_ver == 3'd4) n_pl = {e_pl[24:0], i_stream_byte[6:0]};
                    else n_pl = {e_pl[23:0], i_stream_byte};
                end else if (i_stream_byte != 8'd0) begin
                    n_cf = 2'd1;
                end
                n_pos = e_pos + 4'd1;
                if (e_pos + 4'd1 >= hlen) begin
                    if (v2) begin
                        if (n_fid == ID_TP1) kind = 3'd0;
                        if (n_fid == ID_TAL) kind = 3'd1;
                        if (n_fid == ID_TT2) kind = 3'd2;
                        if (n_fid == ID_TRK) kind = 3'd3;
                    end else begin
                        if (n_fid == ID_TPE1) kind = 3'd0;
                        if (n_fid == ID_TALB) kind = 3'd1;
                        if (n_fid == ID_TIT2) kind = 3'd2;
                        if (n_fid == ID_TRCK) kind = 3'd3;
                    end
                    if (n_fid == 32'd0 && n_pl == 32'd0 && n_cf == 2'd0) begin
                        res.event_res = EV_DONE;
                        push.r0 = res;
                        push.n  = 2'd1;
                        n_phase = PH_DONE;
                    end else if (n_pl == 32'd0) begin
                        do_bnd = 1'b1;
                    end else if (kind != 3'd4) begin
                        n_cf    = kind[1:0];
                        n_phase = PH_FIELD_ENC;
                    end else begin
                        n_phase = PH_SKIP;
                    end
                end
            end
            PH_FIELD_ENC: begin
                res.field_kind = e_cf;
                res.value      = i_stream_byte;
                if (i_stream_byte <= 8'd3) begin
                    res.event_res = EV_ENC;
                    res.last      = (e_pl == 32'd1);
                    n_phase = PH_FIELD_TEXT;
                end else begin
                    res.event_res = EV_BAD;
                    n_phase = PH_SKIP;
                end
                push.r0 = res;
                push.n  = 2'd1;
                n_pl = e_pl - 32'd1;
                if (n_pl == 32'd0) do_bnd = 1'b1;
            end
            PH_FIELD_TEXT: begin
                res.event_res  = EV_TEXT;
                res.field_kind = e_cf;
                res.value      = i_stream_byte;
                res.last       = (e_pl == 32'd1);
                push.r0 = res;
                push.n  = 2'd1;
                if (e_pl != 32'd0) n_pl = e_pl - 32'd1;
                if (n_pl == 32'd0) do_bnd = 1'b1;
            end
            PH_SKIP: begin
                if (e_pl != 32'd0) n_pl = e_pl - 32'd1;
                if (n_pl == 32'd0) do_bnd = 1'b1;
            end
            default: begin
            end
        endcase

        // frame header length follows the version just taken from the main header
        bnd_ok = ({1'b0, n_cons} + ((n_ver == 3'd2) ? 30'd6 : 30'd10)) < {2'b0, n_tlen};
        if (do_bnd) begin
            if (bnd_ok) begin
                n_phase = PH_FRAME;
                n_pos = '0; n_fid = '0; n_pl = '0; n_cf = '0;
            end else begin
                res = '0;
                res.event_res = EV_DONE;
                if (push.n == 2'd0) push.r0 = res;
                else push.r1 = res;
                push.n  = push.n + 2'd1;
                n_phase = PH_DONE;
            end
        end
        if (!acc) push.n = 2'd0;
    end

    assign o_push = push;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE; r_pos <= '0; r_ver <= '0; r_flags <= '0;
            r_tlen <= '0; r_cons <= '0; r_fid <= '0; r_pl <= '0;
            r_cf <= '0; r_skip <= '0;
        end else if (acc) begin
            r_phase <= n_phase; r_pos <= n_pos; r_ver <= n_ver; r_flags <= n_flags;
            r_tlen <= n_tlen; r_cons <= n_cons; r_fid <= n_fid; r_pl <= n_pl;
            r_cf <= n_cf; r_skip <= n_skip;
        end
    end
endmodule

>>> rtl/core/id3p_queue.sv
module id3p_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  id3p_pkg::t_push i_push,
    input  logic            i_pop,
    output id3p_pkg::t_res  o_head,
    output logic [2:0]      o_level,
    output logic            o_space
);
    import id3p_pkg::*;

    t_res       r_mem [4];
    logic [1:0] r_wp, r_rp;
    logic [2:0] r_lvl;

    assign o_head  = r_mem[r_rp];
    assign o_level = r_lvl;
    // leave room for the two results one request can raise
    assign o_space = (r_lvl <= 3'd2);

    always_ff @(posedge i_clk) begin
        if (i_push.n != 2'd0) r_mem[r_wp] <= i_push.r0;
        if (i_push.n == 2'd2) r_mem[r_wp + 2'd1] <= i_push.r1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= '0; r_rp <= '0; r_lvl <= '0;
        end else begin
            r_wp  <= r_wp + i_push.n;
            r_rp  <= r_rp + {1'b0, i_pop};
            r_lvl <= r_lvl + {1'b0, i_push.n} - {2'b0, i_pop};
        end
    end
endmodule

>>> rtl/core/id3p_back.sv
module id3p_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  id3p_pkg::t_res i_head,
    input  logic [2:0]     i_level,
    output logic           o_pop,
    output logic           o_valid,
    input  logic           i_ready,
    output logic [2:0]     o_event_res,
    output logic [1:0]     o_field_kind,
    output logic [7:0]     o_value,
    output logic           o_last
);
    import id3p_pkg::*;

    logic r_valid;
    t_res r_res;

    assign o_pop        = (i_level != 3'd0) && (!r_valid || i_ready);
    assign o_valid      = r_valid;
    assign o_event_res  = r_res.event_res;
    assign o_field_kind = r_res.field_kind;
    assign o_value      = r_res.value;
    assign o_last       = r_res.last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_pop) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) r_res <= i_head;
    end
endmodule

>>> rtl/core/id3v2_tag_frame_parser_core.sv
// ID3v2 tag parser: takes one file byte per cycle and emits tag-accepted, field-encoding,
// text-byte, tag-done and invalid results. A request raises at most two results; they pass
// through a four-entry queue to an output register, so bytes flow at one per cycle while the
// queue holds two free entries, and results leave at one per cycle while i_ready is high.
`include "id3v2_tag_frame_parser_core_defines.svh"
module id3v2_tag_frame_parser_core (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [7:0] i_stream_byte,
    input  logic       i_file_start,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [2:0] o_event_res,
    output logic [1:0] o_field_kind,
    output logic [7:0] o_value,
    output logic       o_last
);
    import id3p_pkg::*;

    t_push      push;
    t_res       head;
    logic [2:0] level;
    logic       space;
    logic       pop;

    id3p_front u_front (
        .i_clk, .i_rst_n, .i_valid, .o_ready, .i_stream_byte, .i_file_start,
        .i_space(space), .o_push(push)
    );

    id3p_queue u_queue (
        .i_clk, .i_rst_n, .i_push(push), .i_pop(pop),
        .o_head(head), .o_level(level), .o_space(space)
    );

    id3p_back u_back (
        .i_clk, .i_rst_n, .i_head(head), .i_level(level), .o_pop(pop),
        .o_valid, .i_ready, .o_event_res, .o_field_kind, .o_value, .o_last
    );

    `ID3P_ASSERT(a_level_max, level <= 3'd4, "queue overfilled")
    `ID3P_ASSERT(a_push_room, push.n != 2'd0 |-> $past(level) <= 3'd4 && level <= 3'd2, "push without room")
    `ID3P_ASSERT_NORST(a_rst_idle, !i_rst_n |=> !o_valid && level == 3'd0, "output valid after reset")
endmodule
